// ----- src/ut2c_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ut2c_pkg
// Shared widths, constants, reciprocals and types for the unix time to
// calendar pipeline.
// ----------------------------------------------------------------------------
package ut2c_pkg;

	// field widths of the ports
	localparam int IN_W    = 37;
	localparam int YEAR_W  = 13;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;

	// internal widths
	localparam int RAW_W     = IN_W - 1;       // magnitude of a non-negative count
	localparam int LO_W      = 7;              // 86400 = 675 << 7
	localparam int X_W       = RAW_W - LO_W;   // seconds >> 7
	localparam int DAYS_W    = 20;
	localparam int REM_W     = 10;             // remainder of the divide by 675
	localparam int SOD_W     = REM_W + LO_W;
	localparam int Z_W       = 21;             // day count shifted to 0000-03-01
	localparam int DOE_W     = 18;
	localparam int ERA_IDX_W = 3;
	localparam int Q1460_W   = 7;
	localparam int CENT_W    = 3;
	localparam int YOE_W     = 9;
	localparam int YCENT_W   = 2;
	localparam int DOY_W     = 9;
	localparam int MP_W      = 4;
	localparam int MSR_W     = 12;             // seconds within the hour

	// pipeline depth
	localparam int SPLIT_LAT    = 2;
	localparam int CIVIL_LAT    = 8;
	localparam int TOD_CALC_LAT = 4;
	localparam int TOD_PAD      = CIVIL_LAT - TOD_CALC_LAT;
	localparam int TOTAL_LAT    = 1 + SPLIT_LAT + CIVIL_LAT;

	// calendar constants
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN  = 60;
	localparam int DAY_DIV       = 675;        // seconds per day >> 7
	localparam int DAYS_PER_ERA  = 146097;
	localparam int DAYS_PER_CENT = 36524;
	localparam int DAYS_PER_QUAD = 1460;
	localparam int DAYS_PER_YEAR = 365;
	localparam int YEARS_PER_ERA = 400;
	localparam int YEARS_PER_CENT = 100;
	localparam int EPOCH_SHIFT   = 719468;     // days from 0000-03-01 to the epoch
	localparam int ERA_MIN       = 4;          // era of day zero
	localparam int ERA_SPAN      = 6;          // eras reachable above ERA_MIN
	localparam int DOE_BIAS      = EPOCH_SHIFT - ERA_MIN * DAYS_PER_ERA;
	localparam int MP_JAN        = 10;         // march-based index of january
	localparam int MP_MAR_OFS    = 3;
	localparam int MONTHS        = 12;

	// reciprocals: m = ceil(2^k / d) with k = input bits + divisor bits, exact
	localparam int K_675      = X_W + 10;
	localparam int RCP_675_W  = 30;
	localparam logic [RCP_675_W-1:0] RCP_675 = RCP_675_W'(
		((64'd1 << K_675) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));

	localparam int K_1460     = DOE_W + 11;
	localparam int RCP_1460_W = 19;
	localparam logic [RCP_1460_W-1:0] RCP_1460 = RCP_1460_W'(
		((64'd1 << K_1460) + 64'(DAYS_PER_QUAD) - 64'd1) / 64'(DAYS_PER_QUAD));

	localparam int K_365      = DOE_W + 9;
	localparam int RCP_365_W  = 19;
	localparam logic [RCP_365_W-1:0] RCP_365 = RCP_365_W'(
		((64'd1 << K_365) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));

	// (5 * doy + 2) / 153 folded into one multiply and one add
	localparam int K_153   = 19;
	localparam int MPP_W   = 24;
	localparam int RCP_153 = ((1 << K_153) + 153 - 1) / 153;
	localparam logic [MPP_W-1:0] MP_MUL = MPP_W'(5 * RCP_153);
	localparam logic [MPP_W-1:0] MP_ADD = MPP_W'(2 * RCP_153);

	localparam int K_3600     = SOD_W + 12;
	localparam int RCP_3600_W = 18;
	localparam logic [RCP_3600_W-1:0] RCP_3600 = RCP_3600_W'(
		((64'd1 << K_3600) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));

	localparam int K_60     = MSR_W + 6;
	localparam int RCP_60_W = 13;
	localparam logic [RCP_60_W-1:0] RCP_60 = RCP_60_W'(
		((64'd1 << K_60) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));

	// types
	typedef logic [DAYS_W-1:0] days_t;
	typedef logic [SOD_W-1:0]  sod_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} cal_t;

	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SEC_W-1:0]  second;
	} hms_t;

	// first day of a march-based month within the year, (153 * mp + 2) / 5
	function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
		logic [DOY_W-1:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/unix_time_to_calendar_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// unix_time_to_calendar_core
// Converts a signed count of seconds since 1970-01-01 UTC into Gregorian
// year, month, day, hour, minute and second.
// ----------------------------------------------------------------------------
// Usage:
// - input channel in_valid / in_ready carries unix_seconds; an item is taken
//   on a clock edge where both are high
// - output channel out_valid / out_ready carries unknown and the six fields
// - a negative count gives unknown = 1 with every other field zero
// - the path runs through an input register, 2 day-split stages and 8
//   calendar stages; time of day runs beside the calendar stages
// - one item per cycle sustained while the receiver does not stall;
//   every stage is a register and the divides by constants are
//   reciprocal multiplies, one per stage, or compare chains for the
//   eras and centuries
// - when the receiver stalls (out_valid high, out_ready low) the whole
//   pipeline holds and in_ready drops; nothing is lost or repeated
// - reset clears all valid bits; the pipeline is empty right after reset
// ----------------------------------------------------------------------------
module unix_time_to_calendar_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [ut2c_pkg::IN_W-1:0]  unix_seconds,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              unknown,
	output logic [ut2c_pkg::YEAR_W-1:0]       year,
	output logic [ut2c_pkg::MONTH_W-1:0]      month,
	output logic [ut2c_pkg::DAY_W-1:0]        day,
	output logic [ut2c_pkg::HOUR_W-1:0]       hour,
	output logic [ut2c_pkg::MIN_W-1:0]        minute,
	output logic [ut2c_pkg::SEC_W-1:0]        second
);
	import ut2c_pkg::*;

	logic                 adv;
	logic [TOTAL_LAT-1:0] vld_q;
	logic [TOTAL_LAT-1:0] neg_q;
	logic [RAW_W-1:0]     raw_s1;
	days_t                days;
	sod_t                 sod;
	cal_t                 cal;
	hms_t                 hms;

	// pipeline moves unless a finished item waits
	assign adv      = !vld_q[TOTAL_LAT-1] || out_ready;
	assign in_ready = adv;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], in_valid};
		end
	end

	// input register and sign flag line
	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s1 <= unix_seconds[RAW_W-1:0];
			neg_q  <= {neg_q[TOTAL_LAT-2:0], unix_seconds[IN_W-1]};
		end
	end

	ut2c_day_split u_split (
		.clk  (clk),
		.en   (adv),
		.raw  (raw_s1),
		.days (days),
		.sod  (sod)
	);

	ut2c_civil u_civil (
		.clk  (clk),
		.en   (adv),
		.days (days),
		.cal  (cal)
	);

	ut2c_tod u_tod (
		.clk (clk),
		.en  (adv),
		.sod (sod),
		.hms (hms)
	);

	// outputs, zeroed for a negative count
	assign out_valid = vld_q[TOTAL_LAT-1];
	assign unknown   = neg_q[TOTAL_LAT-1];
	assign year      = unknown ? '0 : cal.year;
	assign month     = unknown ? '0 : cal.month;
	assign day       = unknown ? '0 : cal.day;
	assign hour      = unknown ? '0 : hms.hour;
	assign minute    = unknown ? '0 : hms.minute;
	assign second    = unknown ? '0 : hms.second;

endmodule
`default_nettype wire

// ----- src/ut2c_day_split.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ut2c_day_split
// Two-stage split of a second count into whole days and seconds of the day,
// using a reciprocal multiply for the divide by 675 after a shift by 7.
// ----------------------------------------------------------------------------
module ut2c_day_split (
	input  logic                      clk,
	input  logic                      en,
	input  logic [ut2c_pkg::RAW_W-1:0] raw,
	output ut2c_pkg::days_t           days,
	output ut2c_pkg::sod_t            sod
);
	import ut2c_pkg::*;

	logic [X_W+RCP_675_W-1:0] prod;
	logic [X_W-1:0]           x_s2;
	logic [LO_W-1:0]          lo_s2;
	days_t                    q_s2;
	logic [X_W-1:0]           back;
	logic [X_W-1:0]           rem_full;
	days_t                    days_s3;
	sod_t                     sod_s3;

	// quotient by reciprocal
	assign prod = (X_W+RCP_675_W)'(raw[RAW_W-1:LO_W]) * (X_W+RCP_675_W)'(RCP_675);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2  <= raw[RAW_W-1:LO_W];
			lo_s2 <= raw[LO_W-1:0];
			q_s2  <= DAYS_W'(prod >> K_675);
		end
	end

	// remainder and seconds of the day
	assign back     = X_W'(q_s2) * X_W'(DAY_DIV);
	assign rem_full = x_s2 - back;

	always_ff @(posedge clk) begin
		if (en) begin
			days_s3 <= q_s2;
			sod_s3  <= {rem_full[REM_W-1:0], lo_s2};
		end
	end

	assign days = days_s3;
	assign sod  = sod_s3;

endmodule
`default_nettype wire

// ----- src/ut2c_civil.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ut2c_civil
// Eight-stage conversion of a day count since the epoch into year, month and
// day of the proleptic Gregorian calendar (march-based era arithmetic).
// ----------------------------------------------------------------------------
module ut2c_civil (
	input  logic            clk,
	input  logic            en,
	input  ut2c_pkg::days_t days,
	output ut2c_pkg::cal_t  cal
);
	import ut2c_pkg::*;

	logic [ERA_IDX_W-1:0]      era_cnt;
	logic [ERA_IDX_W-1:0]      era_s4, era_s5, era_s6, era_s7, era_s8, era_s9, era_s10;
	days_t                     days_s4;
	logic [DOE_W-1:0]          doe_n;
	logic [DOE_W-1:0]          doe_s5, doe_s6, doe_s7, doe_s8;
	logic [DOE_W+RCP_1460_W-1:0] prod1460;
	logic [CENT_W-1:0]         cent_n;
	logic [Q1460_W-1:0]        q1460_s6;
	logic [CENT_W-1:0]         cent_s6;
	logic                      last_s6;
	logic [DOE_W-1:0]          t_s7;
	logic [DOE_W+RCP_365_W-1:0] prod365;
	logic [YOE_W-1:0]          yoe_s8, yoe_s9, yoe_s10;
	logic [YCENT_W-1:0]        ycent;
	logic [DOE_W-1:0]          doy_n;
	logic [DOY_W-1:0]          doy_s9, doy_s10;
	logic [MPP_W-1:0]          prod153;
	logic [MP_W-1:0]           mp_s10;
	cal_t                      cal_n;
	cal_t                      cal_s11;

	// stage 4: era index by compare against era boundaries
	always_comb begin
		era_cnt = '0;
		for (int j = 1; j <= ERA_SPAN; j++) begin
			if (days >= DAYS_W'(DAYS_PER_ERA * (ERA_MIN + j) - EPOCH_SHIFT)) begin
				era_cnt = era_cnt + ERA_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			era_s4  <= era_cnt;
			days_s4 <= days;
		end
	end

	// stage 5: day of era
	assign doe_n = DOE_W'(Z_W'(days_s4) + Z_W'(DOE_BIAS) - Z_W'(era_s4) * Z_W'(DAYS_PER_ERA));

	always_ff @(posedge clk) begin
		if (en) begin
			doe_s5 <= doe_n;
			era_s5 <= era_s4;
		end
	end

	// stage 6: quads, centuries and the last day of the era
	assign prod1460 = (DOE_W+RCP_1460_W)'(doe_s5) * (DOE_W+RCP_1460_W)'(RCP_1460);

	always_comb begin
		cent_n = '0;
		for (int k = 1; k <= 4; k++) begin
			if (doe_s5 >= DOE_W'(DAYS_PER_CENT * k)) begin
				cent_n = cent_n + CENT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q1460_s6 <= Q1460_W'(prod1460 >> K_1460);
			cent_s6  <= cent_n;
			last_s6  <= (doe_s5 == DOE_W'(DAYS_PER_ERA - 1));
			doe_s6   <= doe_s5;
			era_s6   <= era_s5;
		end
	end

	// stage 7: leap-corrected day count ahead of the year divide
	always_ff @(posedge clk) begin
		if (en) begin
			t_s7   <= doe_s6 - DOE_W'(q1460_s6) + DOE_W'(cent_s6) - DOE_W'(last_s6);
			doe_s7 <= doe_s6;
			era_s7 <= era_s6;
		end
	end

	// stage 8: year of era
	assign prod365 = (DOE_W+RCP_365_W)'(t_s7) * (DOE_W+RCP_365_W)'(RCP_365);

	always_ff @(posedge clk) begin
		if (en) begin
			yoe_s8 <= YOE_W'(prod365 >> K_365);
			doe_s8 <= doe_s7;
			era_s8 <= era_s7;
		end
	end

	// stage 9: day of the march-based year
	always_comb begin
		ycent = '0;
		for (int k = 1; k <= 3; k++) begin
			if (yoe_s8 >= YOE_W'(YEARS_PER_CENT * k)) begin
				ycent = ycent + YCENT_W'(1);
			end
		end
	end

	assign doy_n = doe_s8 - (DOE_W'(yoe_s8) * DOE_W'(DAYS_PER_YEAR)
		+ DOE_W'(yoe_s8 >> 2) - DOE_W'(ycent));

	always_ff @(posedge clk) begin
		if (en) begin
			doy_s9 <= DOY_W'(doy_n);
			yoe_s9 <= yoe_s8;
			era_s9 <= era_s8;
		end
	end

	// stage 10: march-based month
	assign prod153 = MPP_W'(doy_s9) * MP_MUL + MP_ADD;

	always_ff @(posedge clk) begin
		if (en) begin
			mp_s10  <= MP_W'(prod153 >> K_153);
			doy_s10 <= doy_s9;
			yoe_s10 <= yoe_s9;
			era_s10 <= era_s9;
		end
	end

	// stage 11: calendar fields, january and february belong to the next year
	always_comb begin
		cal_n.day = DAY_W'(doy_s10 - month_start(mp_s10) + DOY_W'(1));
		if (mp_s10 < MP_W'(MP_JAN)) begin
			cal_n.month = MONTH_W'(mp_s10 + MP_W'(MP_MAR_OFS));
		end else begin
			cal_n.month = MONTH_W'(mp_s10 - MP_W'(MONTHS - MP_MAR_OFS));
		end
		cal_n.year = YEAR_W'(yoe_s10)
			+ (YEAR_W'(era_s10) + YEAR_W'(ERA_MIN)) * YEAR_W'(YEARS_PER_ERA)
			+ YEAR_W'(mp_s10 >= MP_W'(MP_JAN));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cal_s11 <= cal_n;
		end
	end

	assign cal = cal_s11;

endmodule
`default_nettype wire

// ----- src/ut2c_tod.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ut2c_tod
// Hour, minute and second from the seconds of the day in four stages, then
// delayed to line up with the calendar pipeline.
// ----------------------------------------------------------------------------
module ut2c_tod (
	input  logic           clk,
	input  logic           en,
	input  ut2c_pkg::sod_t sod,
	output ut2c_pkg::hms_t hms
);
	import ut2c_pkg::*;

	logic [SOD_W+RCP_3600_W-1:0] prod3600;
	logic [HOUR_W-1:0]           hour_s4, hour_s5, hour_s6;
	sod_t                        sod_s4;
	logic [MSR_W-1:0]            ms_s5, ms_s6;
	logic [MSR_W+RCP_60_W-1:0]   prod60;
	logic [MIN_W-1:0]            min_s6;
	hms_t                        hms_s7;
	hms_t                        pad_q [TOD_PAD];

	// stage 4: hour
	assign prod3600 = (SOD_W+RCP_3600_W)'(sod) * (SOD_W+RCP_3600_W)'(RCP_3600);

	always_ff @(posedge clk) begin
		if (en) begin
			hour_s4 <= HOUR_W'(prod3600 >> K_3600);
			sod_s4  <= sod;
		end
	end

	// stage 5: seconds within the hour
	always_ff @(posedge clk) begin
		if (en) begin
			ms_s5   <= MSR_W'(sod_s4 - SOD_W'(hour_s4) * SOD_W'(SECS_PER_HOUR));
			hour_s5 <= hour_s4;
		end
	end

	// stage 6: minute
	assign prod60 = (MSR_W+RCP_60_W)'(ms_s5) * (MSR_W+RCP_60_W)'(RCP_60);

	always_ff @(posedge clk) begin
		if (en) begin
			min_s6  <= MIN_W'(prod60 >> K_60);
			ms_s6   <= ms_s5;
			hour_s6 <= hour_s5;
		end
	end

	// stage 7: second
	always_ff @(posedge clk) begin
		if (en) begin
			hms_s7.hour   <= hour_s6;
			hms_s7.minute <= min_s6;
			hms_s7.second <= SEC_W'(ms_s6 - MSR_W'(min_s6) * MSR_W'(SECS_PER_MIN));
		end
	end

	// delay line to match the calendar latency
	always_ff @(posedge clk) begin
		if (en) begin
			pad_q[0] <= hms_s7;
			for (int i = 1; i < TOD_PAD; i++) begin
				pad_q[i] <= pad_q[i-1];
			end
		end
	end

	assign hms = pad_q[TOD_PAD-1];

endmodule
`default_nettype wire
